// ----- hdl/fabw_pkg.sv -----
// fabw_pkg: shared types, register indexes and arithmetic helpers for the
// framebuffer alpha blend writer. No dependencies.
`timescale 1ns / 1ps

package fabw_pkg;

  // Colour lanes worked side by side: red, green, blue.
  localparam int LANES = 3;

  // Configuration port data width (widest register).
  localparam int CFG_W = 8;

  // Register indexes on the configuration port.
  localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_PEN_MODE      = 2'd2;
  localparam logic [1:0] CFG_ERASE_ALPHA   = 2'd3;

  // Item command codes.
  localparam logic CMD_BLEND = 1'b0;

  // Pen mode codes.
  localparam logic PEN_ERASE = 1'b1;

  // ceil(2^31 / 255); exact floor(t / 255) for t up to 255^3.
  localparam logic [23:0] RECIP255 = 24'h808081;

  // ceil(2^40 / 65025); exact floor(t / 65025) for t up to 255^3.
  localparam logic [24:0] RECIP65025 = 25'h1020305;

  typedef struct packed {
    logic              cmd;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [7:0]        src_red;
    logic [7:0]        src_green;
    logic [7:0]        src_blue;
    logic [7:0]        src_alpha;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       inside_res;
    logic       written;
  } out_item_t;

  typedef struct packed {
    logic [6:0] screen_width;
    logic [6:0] screen_height;
    logic       pen_mode;
    logic [7:0] erase_alpha;
  } cfg_t;

  // Controller -> datapath commands.
  typedef struct packed {
    logic clear_en;
    logic accept;
    logic rd_en;
    logic mul1;
    logic mul2;
    logic mul3;
    logic div_start;
    logic emit_zero;
    logic emit_stored;
    logic commit;
  } ctl_cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic clear_last;
    logic in_frame;
    logic update;
    logic erase;
    logic div_done;
  } ctl_stat_t;

  // floor(t / 255) by reciprocal multiply, t < 2^24 and t <= 255^3.
  function automatic logic [15:0] div255(input logic [23:0] t);
    logic [47:0] prod;
    prod = 48'(t) * 48'(RECIP255);
    return prod[46:31];
  endfunction

  // floor(t / 65025) by reciprocal multiply, t <= 255^3.
  function automatic logic [7:0] div65025(input logic [23:0] t);
    logic [48:0] prod;
    prod = 49'(t) * 49'(RECIP65025);
    return prod[47:40];
  endfunction

endpackage

// ----- hdl/framebuffer_alpha_blend_writer_unit.sv -----
// Framebuffer alpha blend writer: one result word per accepted input word.
// Outside words are answered after the lookup; read, no-op and erase words after
// the store read; blends after three pipelined multiply stages and a 16-step divider.
// A new word can be accepted in the cycle its predecessor's result shows.
// Reset: synchronous, active low; then busy stays high while the store is cleared,
// one entry a cycle. Config writes only when idle.
`timescale 1ns / 1ps

module framebuffer_alpha_blend_writer_unit #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel: word taken when start && !busy
  input  logic                       start,
  output logic                       busy,
  input  fabw_pkg::in_item_t         in_data,
  // result channel: one-cycle strobe, no back-pressure
  output logic                       out_valid,
  output fabw_pkg::out_item_t        out_data,
  // configuration write port
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [fabw_pkg::CFG_W-1:0] cfg_wdata
);

  fabw_pkg::cfg_t      cfg_r;
  fabw_pkg::ctl_cmd_t  cmd;
  fabw_pkg::ctl_stat_t stat;

  // Configuration registers. Each write keeps only the register's own width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width  <= 7'd64;
      cfg_r.screen_height <= 7'd64;
      cfg_r.pen_mode      <= 1'b0;
      cfg_r.erase_alpha   <= 8'd255;
    end else if (cfg_we) begin
      case (cfg_index)
        fabw_pkg::CFG_SCREEN_WIDTH:  cfg_r.screen_width  <= cfg_wdata[6:0];
        fabw_pkg::CFG_SCREEN_HEIGHT: cfg_r.screen_height <= cfg_wdata[6:0];
        fabw_pkg::CFG_PEN_MODE:      cfg_r.pen_mode      <= cfg_wdata[0];
        fabw_pkg::CFG_ERASE_ALPHA:   cfg_r.erase_alpha   <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer: clears the store after reset, then walks each word through lookup,
  // store read and, for a blend, the multiply stages and the divider, and emits or commits.
  fabw_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Datapath: bounds check and address, pixel store, over/unpremultiply
  // arithmetic, erase, and the registered result.
  fabw_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ----- hdl/fabw_div.sv -----
// fabw_div: restoring radix-2 divider, one quotient bit per cycle, three
// colour lanes sharing one divisor. Depends on fabw_pkg.
`timescale 1ns / 1ps

module fabw_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] num [fabw_pkg::LANES],
  input  logic [7:0]  den,
  output logic [7:0]  quo [fabw_pkg::LANES],
  output logic        done
);

  localparam int NUM_W = 16;
  localparam int STEPS = NUM_W;
  localparam int CNT_W = $clog2(STEPS);

  logic             run_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [7:0]       den_r;
  logic [7:0]       rem_r   [fabw_pkg::LANES];
  logic [7:0]       rem_nxt [fabw_pkg::LANES];
  logic [NUM_W-1:0] quo_r   [fabw_pkg::LANES];
  logic [NUM_W-1:0] quo_nxt [fabw_pkg::LANES];

  always_comb begin
    logic [8:0] shifted;
    logic [9:0] trial;
    for (int l = 0; l < fabw_pkg::LANES; l++) begin
      shifted = {rem_r[l], quo_r[l][NUM_W-1]};
      trial   = {1'b0, shifted} - {2'b00, den_r};
      if (trial[9]) begin
        rem_nxt[l] = shifted[7:0];
        quo_nxt[l] = {quo_r[l][NUM_W-2:0], 1'b0};
      end else begin
        rem_nxt[l] = trial[7:0];
        quo_nxt[l] = {quo_r[l][NUM_W-2:0], 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      for (int l = 0; l < fabw_pkg::LANES; l++) begin
        rem_r[l] <= '0;
        quo_r[l] <= num[l];
      end
    end else if (run_r) begin
      for (int l = 0; l < fabw_pkg::LANES; l++) begin
        rem_r[l] <= rem_nxt[l];
        quo_r[l] <= quo_nxt[l];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < fabw_pkg::LANES; l++) begin
      quo[l] = quo_r[l][7:0];
    end
  end

  assign done = done_r;

endmodule

// ----- hdl/fabw_datapath.sv -----
// fabw_datapath: coordinate check, pixel store, blend and erase arithmetic,
// result register. Depends on fabw_pkg and fabw_div.
`timescale 1ns / 1ps

module fabw_datapath #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fabw_pkg::cfg_t      cfg,
  input  fabw_pkg::in_item_t  in_data,
  input  fabw_pkg::ctl_cmd_t  cmd,
  output fabw_pkg::ctl_stat_t stat,
  output logic                out_valid,
  output fabw_pkg::out_item_t out_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDXW  = (AW > 14) ? AW : 14;

  // pixel store, red in the low byte, alpha on top
  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_r;
  logic [AW-1:0] clr_addr_r;

  fabw_pkg::in_item_t item_r;
  logic          inside_r;
  logic          update_r;
  logic [AW-1:0] addr_r;

  logic [6:0]      w_act;
  logic [6:0]      h_act;
  logic            inside_nxt;
  logic [IDXW-1:0] idx_wide;

  logic [7:0]  sc [fabw_pkg::LANES];
  logic [7:0]  oc [fabw_pkg::LANES];
  logic [7:0]  sa;
  logic [7:0]  inv_sa;
  logic [7:0]  oa;

  logic [15:0] ps_r [fabw_pkg::LANES];
  logic [15:0] po_r [fabw_pkg::LANES];
  logic [15:0] pa_r;
  logic [7:0]  qs_r [fabw_pkg::LANES];
  logic [23:0] to_r [fabw_pkg::LANES];
  logic [7:0]  na_r;
  logic [7:0]  cp_r [fabw_pkg::LANES];

  logic [15:0] div_num [fabw_pkg::LANES];
  logic [7:0]  div_quo [fabw_pkg::LANES];
  logic        div_done;

  logic [7:0]  erase_a;
  logic [31:0] new_pix;

  logic                out_valid_r;
  fabw_pkg::out_item_t out_data_r;

  // active size, clipped to the store
  assign w_act = (32'(cfg.screen_width) < MAX_WIDTH) ? cfg.screen_width : 7'(MAX_WIDTH);
  assign h_act = (32'(cfg.screen_height) < MAX_HEIGHT) ? cfg.screen_height : 7'(MAX_HEIGHT);

  assign inside_nxt = !in_data.pos_x[15] && (in_data.pos_x[14:0] < 15'(w_act)) &&
                      !in_data.pos_y[15] && (in_data.pos_y[14:0] < 15'(h_act));

  // only the low 7 bits of x and y matter once the point is inside
  assign idx_wide = IDXW'(in_data.pos_x[6:0]) + IDXW'(in_data.pos_y[6:0]) * IDXW'(w_act);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r   <= in_data;
      inside_r <= inside_nxt;
      update_r <= (in_data.cmd == fabw_pkg::CMD_BLEND) && (in_data.src_alpha != 8'd0);
      addr_r   <= idx_wide[AW-1:0];
    end
  end

  // store: one write port (clear or commit), one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clear_en) begin
      mem[clr_addr_r] <= '0;
    end else if (cmd.commit) begin
      mem[addr_r] <= new_pix;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clear_en) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  assign sc[0]  = item_r.src_red;
  assign sc[1]  = item_r.src_green;
  assign sc[2]  = item_r.src_blue;
  assign sa     = item_r.src_alpha;
  assign inv_sa = ~item_r.src_alpha;
  assign oa     = rdata_r[31:24];

  always_comb begin
    for (int l = 0; l < fabw_pkg::LANES; l++) begin
      oc[l] = rdata_r[8*l +: 8];
    end
  end

  // over compositing, split across the mul1, mul2 and mul3 stages
  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      for (int l = 0; l < fabw_pkg::LANES; l++) begin
        ps_r[l] <= 16'(sc[l]) * 16'(sa);
        po_r[l] <= 16'(oc[l]) * 16'(oa);
      end
      pa_r <= 16'(oa) * 16'(inv_sa);
    end
    if (cmd.mul2) begin
      for (int l = 0; l < fabw_pkg::LANES; l++) begin
        qs_r[l] <= 8'(fabw_pkg::div255(24'(ps_r[l])));
        to_r[l] <= 24'(po_r[l]) * 24'(inv_sa);
      end
      // sa + oa*(255-sa)/255 never exceeds 255 and is nonzero for sa != 0
      na_r <= sa + 8'(fabw_pkg::div255(24'(pa_r)));
    end
    if (cmd.mul3) begin
      // stored share: oc*oa*(255-sa) / (255*255), wrapped to 8 bits
      for (int l = 0; l < fabw_pkg::LANES; l++) begin
        cp_r[l] <= qs_r[l] + fabw_pkg::div65025(to_r[l]);
      end
    end
  end

  // un-premultiply: c * 255 / a
  always_comb begin
    for (int l = 0; l < fabw_pkg::LANES; l++) begin
      div_num[l] = {cp_r[l], 8'h00} - 16'(cp_r[l]);
    end
  end

  fabw_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (na_r),
    .quo   (div_quo),
    .done  (div_done)
  );

  assign erase_a = (cfg.erase_alpha >= oa) ? 8'd0 : (oa - cfg.erase_alpha);
  assign new_pix = (cfg.pen_mode == fabw_pkg::PEN_ERASE) ? {erase_a, rdata_r[23:0]}
                                                         : {na_r, div_quo[2], div_quo[1],
                                                            div_quo[0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_zero | cmd.emit_stored | cmd.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_zero) begin
      out_data_r <= '0;
    end else if (cmd.emit_stored) begin
      out_data_r <= {rdata_r[7:0], rdata_r[15:8], rdata_r[23:16], rdata_r[31:24], 1'b1, 1'b0};
    end else if (cmd.commit) begin
      out_data_r <= {new_pix[7:0], new_pix[15:8], new_pix[23:16], new_pix[31:24], 1'b1, 1'b1};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign stat.clear_last = (clr_addr_r == AW'(DEPTH - 1));
  assign stat.in_frame   = inside_r;
  assign stat.update     = update_r;
  assign stat.erase      = (cfg.pen_mode == fabw_pkg::PEN_ERASE);
  assign stat.div_done   = div_done;

endmodule

// ----- hdl/fabw_ctrl.sv -----
// fabw_ctrl: sequencer for store clearing and the per-word read-modify-write.
// Depends on fabw_pkg.
`timescale 1ns / 1ps

module fabw_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  fabw_pkg::ctl_stat_t stat,
  output fabw_pkg::ctl_cmd_t  cmd,
  output logic                busy
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_LOOK  = 3'd2;
  localparam logic [2:0] ST_FETCH = 3'd3;
  localparam logic [2:0] ST_MUL2  = 3'd4;
  localparam logic [2:0] ST_MUL3  = 3'd5;
  localparam logic [2:0] ST_DIVS  = 3'd6;
  localparam logic [2:0] ST_DIVW  = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (stat.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (!stat.in_frame) begin
          cmd.emit_zero = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (!stat.update) begin
          cmd.emit_stored = 1'b1;
          state_nxt       = ST_IDLE;
        end else if (stat.erase) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          cmd.mul1  = 1'b1;
          state_nxt = ST_MUL2;
        end
      end
      ST_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = ST_MUL3;
      end
      ST_MUL3: begin
        cmd.mul3  = 1'b1;
        state_nxt = ST_DIVS;
      end
      ST_DIVS: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIVW;
      end
      ST_DIVW: begin
        if (stat.div_done) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ----- hdl/fabw_checker.sv -----
// fabw_checker: port-level assertions for the blend writer, bound to the top.
// Depends on fabw_pkg and framebuffer_alpha_blend_writer_unit.
`timescale 1ns / 1ps

module fabw_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input fabw_pkg::out_item_t out_data
);

  // reset leaves the unit clearing, with no result pending
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> (busy && !out_valid))
    else $error("unit not busy or result shown after reset");

  // a word just taken never has its result in the next cycle
  a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid)
    else $error("result strobe right after accept");

  // one result per word; the result strobe never stays high on consecutive cycles
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe on two cycles in a row");

  // outside coordinates give an all-zero, unwritten result
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.inside_res) |->
      (out_data.out_red == 8'd0 && out_data.out_green == 8'd0 &&
       out_data.out_blue == 8'd0 && out_data.out_alpha == 8'd0 && !out_data.written))
    else $error("outside result not zero");

endmodule

bind framebuffer_alpha_blend_writer_unit fabw_checker u_fabw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

// ----- test/pixel_blend_checker.sv -----
// pixel_blend_checker: watches the input, result and config ports of the
// framebuffer alpha blend writer, predicts each result word and compares it.
// Depends on fabw_pkg for the word and register index types.
`timescale 1ns / 1ps

module pixel_blend_checker #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  fabw_pkg::in_item_t         in_data,
  input  logic                       out_valid,
  input  fabw_pkg::out_item_t        out_data,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [fabw_pkg::CFG_W-1:0] cfg_wdata,
  output int                         fail_count,
  output int                         pending_words
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

  // shadow copy of the pixel store and of the registers
  logic [31:0] shadow_frame [DEPTH];
  logic [6:0]  reg_width;
  logic [6:0]  reg_height;
  logic        reg_pen;
  logic [7:0]  reg_erase;

  fabw_pkg::out_item_t expected_pixels [$];
  int mismatches = 0;

  // source over stored colour, premultiplied, truncated to 8 bits
  function automatic logic [7:0] over_channel(int unsigned sc, int unsigned sa,
                                              int unsigned oc, int unsigned oa);
    return 8'(sc * sa / 255 + oc * oa * (255 - sa) / (255 * 255));
  endfunction

  // result of one word; updates the shadow store
  function automatic fabw_pkg::out_item_t blend_pixel(fabw_pkg::in_item_t w);
    int                  x, y, lim_w, lim_h;
    int unsigned         idx, sa, oa, na;
    logic [31:0]         pix;
    logic [7:0]          r, g, b, a;
    fabw_pkg::out_item_t res;
    lim_w = (reg_width < MAX_WIDTH) ? int'(reg_width) : MAX_WIDTH;
    lim_h = (reg_height < MAX_HEIGHT) ? int'(reg_height) : MAX_HEIGHT;
    x = $signed(w.pos_x);
    y = $signed(w.pos_y);
    res = '0;
    if (x >= 0 && x < lim_w && y >= 0 && y < lim_h) begin
      idx = x + y * lim_w;
      if (idx >= DEPTH) idx = 0;
      pix = shadow_frame[idx];
      {a, b, g, r} = pix;
      if (w.cmd == fabw_pkg::CMD_BLEND && w.src_alpha != 8'd0) begin
        if (reg_pen == fabw_pkg::PEN_ERASE) begin
          a = (reg_erase >= a) ? 8'd0 : 8'(a - reg_erase);
        end else begin
          sa = w.src_alpha;
          oa = a;
          na = (sa + oa * (255 - sa) / 255) & 255;
          if (na == 0) na = 1;
          r = 8'(over_channel(w.src_red, sa, r, oa) * 255 / na);
          g = 8'(over_channel(w.src_green, sa, g, oa) * 255 / na);
          b = 8'(over_channel(w.src_blue, sa, b, oa) * 255 / na);
          a = 8'(na);
        end
        shadow_frame[idx] = {a, b, g, r};
        res.written = 1'b1;
      end
      res.inside_res = 1'b1;
      res.out_red    = r;
      res.out_green  = g;
      res.out_blue   = b;
      res.out_alpha  = a;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    fabw_pkg::out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) shadow_frame[i] = '0;
      reg_width  = 7'd64;
      reg_height = 7'd64;
      reg_pen    = 1'b0;
      reg_erase  = 8'd255;
      expected_pixels.delete();
    end else begin
      // a result leaving in the same cycle as a new word belongs to an older word
      if (out_valid !== 1'b0) begin
        if (expected_pixels.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result word: r=%0d g=%0d b=%0d a=%0d in=%0b wr=%0b",
                     out_data.out_red, out_data.out_green, out_data.out_blue,
                     out_data.out_alpha, out_data.inside_res, out_data.written);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_data.out_red !== want.out_red || out_data.out_green !== want.out_green ||
              out_data.out_blue !== want.out_blue || out_data.out_alpha !== want.out_alpha ||
              out_data.inside_res !== want.inside_res || out_data.written !== want.written)
          begin
            if (mismatches < 10)
              $display("mismatch: want r=%0d g=%0d b=%0d a=%0d in=%0b wr=%0b, got r=%0d g=%0d b=%0d a=%0d in=%0b wr=%0b",
                       want.out_red, want.out_green, want.out_blue, want.out_alpha,
                       want.inside_res, want.written,
                       out_data.out_red, out_data.out_green, out_data.out_blue,
                       out_data.out_alpha, out_data.inside_res, out_data.written);
            mismatches++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          fabw_pkg::CFG_SCREEN_WIDTH:  reg_width  = cfg_wdata[6:0];
          fabw_pkg::CFG_SCREEN_HEIGHT: reg_height = cfg_wdata[6:0];
          fabw_pkg::CFG_PEN_MODE:      reg_pen    = cfg_wdata[0];
          fabw_pkg::CFG_ERASE_ALPHA:   reg_erase  = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (start && busy === 1'b0) expected_pixels.push_back(blend_pixel(in_data));
    end
    fail_count    <= mismatches;
    pending_words <= expected_pixels.size();
  end

endmodule

// ----- test/testbench.sv -----
// testbench: stimulus and verdict for framebuffer_alpha_blend_writer_unit.
// Depends on fabw_pkg, the unit itself and pixel_blend_checker, which does
// all prediction and comparison.
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_W        = 64;
  localparam int MAX_H        = 64;
  localparam int RANDOM_WORDS = 1250;
  // cycles with neither an accepted word nor a result; covers the store clear
  // after reset with plenty of room to spare
  localparam int STALL_LIMIT  = 25000;
  // longest result latency (blend path) plus margin
  localparam int TAIL_CYCLES  = 30;

  // codes the package leaves implicit
  localparam logic CMD_READ = ~fabw_pkg::CMD_BLEND;
  localparam logic PEN_OVER = ~fabw_pkg::PEN_ERASE;

  logic                       clk       = 1'b0;
  logic                       rst_n     = 1'b0;
  logic                       start     = 1'b0;
  logic                       busy;
  fabw_pkg::in_item_t         in_data   = '0;
  logic                       out_valid;
  fabw_pkg::out_item_t        out_data;
  logic                       cfg_we    = 1'b0;
  logic [1:0]                 cfg_index = '0;
  logic [fabw_pkg::CFG_W-1:0] cfg_wdata = '0;

  int fail_count;
  int pending_words;
  int stall_cycles  = 0;
  int send_idle_pct = 23;
  // active frame size as last configured, used to aim coordinates
  int act_w = MAX_W;
  int act_h = MAX_H;

  framebuffer_alpha_blend_writer_unit #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  pixel_blend_checker #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .pending_words(pending_words)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // watchdog: any accepted word or result restarts the count
  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  function automatic fabw_pkg::in_item_t px_word(logic cmd, int x, int y, logic [7:0] r,
                                                 logic [7:0] g, logic [7:0] b,
                                                 logic [7:0] a);
    fabw_pkg::in_item_t w;
    w.cmd       = cmd;
    w.pos_x     = 16'(x);
    w.pos_y     = 16'(y);
    w.src_red   = r;
    w.src_green = g;
    w.src_blue  = b;
    w.src_alpha = a;
    return w;
  endfunction

  // channel byte with the extremes weighted up
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // raw register value for width/height: often small frames so that pixels get
  // hit again and again, sometimes zero, full size or past the limit (bit 7
  // included, the unit keeps only 7 bits)
  function automatic logic [7:0] rand_dim();
    case ($urandom_range(0, 19))
      0:                          return 8'd0;
      1, 2:                       return 8'($urandom_range(65, 255));
      3, 4:                       return 8'd64;
      5, 6, 7, 8, 9, 10, 11, 12:  return 8'($urandom_range(1, 8));
      default:                    return 8'($urandom_range(9, 64));
    endcase
  endfunction

  // random word aimed at the active frame, plus one cell of margin on each side;
  // a share of fully random coordinates exercises the upper bits
  function automatic fabw_pkg::in_item_t rand_word();
    int x, y;
    if ($urandom_range(0, 99) < 85) begin
      x = int'($urandom_range(0, act_w + 1)) - 1;
      y = int'($urandom_range(0, act_h + 1)) - 1;
    end else begin
      x = $urandom;
      y = $urandom;
    end
    return px_word(($urandom_range(0, 3) == 0) ? CMD_READ : fabw_pkg::CMD_BLEND, x, y,
                   rand_byte(), rand_byte(), rand_byte(), rand_byte());
  endfunction

  // hold the word until start && !busy, then maybe leave a gap
  task automatic send_word(fabw_pkg::in_item_t w);
    start   <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy !== 1'b0);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      start <= 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(4, 30) : $urandom_range(1, 3))
        @(posedge clk);
    end
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain();
    if (start) start <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
  endtask

  // write all four registers back to back while the unit is idle
  task automatic set_config(logic [7:0] w, logic [7:0] h, logic pen, logic [7:0] ea);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= fabw_pkg::CFG_SCREEN_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= fabw_pkg::CFG_SCREEN_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_index <= fabw_pkg::CFG_PEN_MODE;
    cfg_wdata <= 8'(pen);
    @(posedge clk);
    cfg_index <= fabw_pkg::CFG_ERASE_ALPHA;
    cfg_wdata <= ea;
    @(posedge clk);
    cfg_we <= 1'b0;
    act_w = (int'(w[6:0]) < MAX_W) ? int'(w[6:0]) : MAX_W;
    act_h = (int'(h[6:0]) < MAX_H) ? int'(h[6:0]) : MAX_H;
  endtask

  initial begin
    int n_random;
    int phase;
    n_random = 0;
    phase    = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset registers (64x64, blend over); first word waits out the clear
    send_word(px_word(CMD_READ, 0, 0, 8'd0, 8'd0, 8'd0, 8'd0));          // cleared pixel
    send_word(px_word(fabw_pkg::CMD_BLEND, 0, 0, 8'd255, 8'd0, 8'd128, 8'd255)); // opaque
    send_word(px_word(fabw_pkg::CMD_BLEND, 0, 0, 8'd10, 8'd200, 8'd30, 8'd128));
    send_word(px_word(fabw_pkg::CMD_BLEND, 0, 0, 8'd1, 8'd2, 8'd3, 8'd0));  // zero alpha
    send_word(px_word(CMD_READ, 0, 0, 8'd9, 8'd9, 8'd9, 8'd77));         // read ignores src
    send_word(px_word(fabw_pkg::CMD_BLEND, 63, 63, 8'd255, 8'd255, 8'd255, 8'd1));
    send_word(px_word(fabw_pkg::CMD_BLEND, 63, 0, 8'd0, 8'd0, 8'd0, 8'd255));
    // just outside each edge, then the coordinate extremes
    send_word(px_word(fabw_pkg::CMD_BLEND, 64, 0, 8'd50, 8'd50, 8'd50, 8'd255));
    send_word(px_word(fabw_pkg::CMD_BLEND, 0, 64, 8'd50, 8'd50, 8'd50, 8'd255));
    send_word(px_word(fabw_pkg::CMD_BLEND, -1, 5, 8'd50, 8'd50, 8'd50, 8'd255));
    send_word(px_word(fabw_pkg::CMD_BLEND, 5, -1, 8'd50, 8'd50, 8'd50, 8'd255));
    send_word(px_word(fabw_pkg::CMD_BLEND, -32768, 32767, 8'd255, 8'd255, 8'd255, 8'd255));
    send_word(px_word(fabw_pkg::CMD_BLEND, 32767, -32768, 8'd255, 8'd255, 8'd255, 8'd255));
    send_word(px_word(CMD_READ, 63, 63, 8'd0, 8'd0, 8'd0, 8'd0));

    // erase: partial subtract, then floor at zero
    set_config(8'd64, 8'd64, fabw_pkg::PEN_ERASE, 8'd100);
    send_word(px_word(fabw_pkg::CMD_BLEND, 0, 0, 8'd0, 8'd0, 8'd0, 8'd200));
    send_word(px_word(fabw_pkg::CMD_BLEND, 0, 0, 8'd0, 8'd0, 8'd0, 8'd255));
    set_config(8'd64, 8'd64, fabw_pkg::PEN_ERASE, 8'd255);
    send_word(px_word(fabw_pkg::CMD_BLEND, 63, 63, 8'd0, 8'd0, 8'd0, 8'd1));
    send_word(px_word(fabw_pkg::CMD_BLEND, 1, 1, 8'd0, 8'd0, 8'd0, 8'd1)); // empty pixel
    // zero erase amount still reports a write
    set_config(8'd64, 8'd64, fabw_pkg::PEN_ERASE, 8'd0);
    send_word(px_word(fabw_pkg::CMD_BLEND, 63, 0, 8'd0, 8'd0, 8'd0, 8'd9));
    send_word(px_word(fabw_pkg::CMD_BLEND, 63, 0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_word(px_word(CMD_READ, 100, 100, 8'd0, 8'd0, 8'd0, 8'd0));
    // back to over onto a pixel whose alpha was erased to zero
    set_config(8'd64, 8'd64, PEN_OVER, 8'd255);
    send_word(px_word(fabw_pkg::CMD_BLEND, 63, 63, 8'd77, 8'd88, 8'd99, 8'd255));

    // random phases, each under its own register setting; the first few pin
    // down zero, past-limit and single-pixel frames
    while (n_random < RANDOM_WORDS) begin
      case (phase)
        0:       set_config(8'd0, 8'd5, PEN_OVER, 8'd255);
        1:       set_config(8'd127, 8'd127, PEN_OVER, 8'd0);
        2:       set_config(8'd1, 8'd1, fabw_pkg::PEN_ERASE, 8'd0);
        3:       set_config(8'd255, 8'd64, fabw_pkg::PEN_ERASE, 8'd255);
        4:       set_config(8'd3, 8'd0, PEN_OVER, 8'd128);
        default: set_config(rand_dim(), rand_dim(),
                            ($urandom_range(0, 9) < 3) ? fabw_pkg::PEN_ERASE : PEN_OVER,
                            rand_byte());
      endcase
      // sender idles 23 in 100, then 54 in 100, then not at all
      send_idle_pct = (n_random < RANDOM_WORDS / 3)     ? 23 :
                      (n_random < 2 * RANDOM_WORDS / 3) ? 54 : 0;
      repeat ($urandom_range(30, 80)) begin
        send_word(rand_word());
        n_random++;
      end
      phase++;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
